// ===== src/dmf_pkg.sv =====
// Shared constants, types and codes for the delayed-maturity FIFO.
package dmf_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int TICK_W     = 32;
  localparam int LAT_W      = 16;
  localparam int CAP_W      = 5;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LATENCY  = 1'b0,
    CFG_CAPACITY = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_PUSH   = 2'd1,
    ACT_POP    = 2'd2,
    ACT_STATUS = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_DUP_PUSH = 3'd1,
    STS_FULL     = 3'd2,
    STS_DUP_POP  = 3'd3,
    STS_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_RESP,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] data;
    logic [TICK_W-1:0]     maturity;
  } entry_t;

  typedef struct packed {
    logic in_ready;
    logic out_valid;
    logic exec_en;
    logic rd_en;
    logic resp_en;
  } ctrl_t;

endpackage

// ===== src/dmf_mem.sv =====
// Entry store: one write port, one read port with registered read data.
module dmf_mem (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [dmf_pkg::PTR_W-1:0] waddr_i,
  input  dmf_pkg::entry_t          wdata_i,
  input  logic                     re_i,
  input  logic [dmf_pkg::PTR_W-1:0] raddr_i,
  output dmf_pkg::entry_t          rdata_o
);
  import dmf_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/delayed_maturity_fifo.sv =====
// Delayed-maturity FIFO: queue of words that become ready a set number of ticks after push.
//
// One item is handled at a time: an accepted beat updates the pointers, count and marks,
// writes the entry store on a push, then reads the new head back from the store, so the
// result beat is offered after the update, store read and result register steps. The next
// input beat is taken in the cycle after the result beat leaves, so no new item is taken
// while a result waits. The latency and capacity registers may be written whenever the
// block is idle; latency is captured into each entry at push time.
module delayed_maturity_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dmf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dmf_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [dmf_pkg::DATA_WIDTH-1:0] push_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [dmf_pkg::DATA_WIDTH-1:0] head_data_o,
  output logic                          head_ready_o,
  output logic                          queue_full_o,
  output logic                          queue_empty_o,
  output logic [dmf_pkg::CNT_W-1:0]     occupancy_o
);
  import dmf_pkg::*;

  state_e state_q, state_d;
  ctrl_t  ctrl;

  logic [LAT_W-1:0]      latency_q;
  logic [CAP_W-1:0]      cap_q;
  logic [CNT_W-1:0]      eff_cap;

  action_e               act_q;
  logic [DATA_WIDTH-1:0] pdata_q;

  logic [PTR_W-1:0]      head_q, head_d;
  logic [PTR_W-1:0]      tail_q, tail_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [TICK_W-1:0]     tick_q, tick_d;
  logic                  pushed_q, pushed_d;
  logic                  popped_q, popped_d;
  status_e               sts_q, sts_d;

  logic                  mem_we;
  entry_t                mem_wdata;
  entry_t                mem_rdata;
  logic [TICK_W-1:0]     age;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latency_q <= '0;
      cap_q     <= CAP_W'(DEPTH);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LATENCY:  latency_q <= cfg_wdata_i[LAT_W-1:0];
        CFG_CAPACITY: cap_q     <= cfg_wdata_i[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the store depth acts as the depth
  always_comb begin
    priority if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (CNT_W'(cap_q) > CNT_W'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_q);
    end
  end

  // FSM
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: state_d = S_READ;
      S_READ: state_d = S_RESP;
      S_RESP: state_d = S_OUT;
      S_OUT:  if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_q)
      S_IDLE:  ctrl.in_ready  = 1'b1;
      S_EXEC:  ctrl.exec_en   = 1'b1;
      S_READ:  ctrl.rd_en     = 1'b1;
      S_RESP:  ctrl.resp_en   = 1'b1;
      S_OUT:   ctrl.out_valid = 1'b1;
      default: ;
    endcase
  end

  assign in_ready_o  = ctrl.in_ready;
  assign out_valid_o = ctrl.out_valid;

  // input beat capture
  always_ff @(posedge clk_i) begin
    if (ctrl.in_ready && in_valid_i) begin
      act_q   <= action_e'(action_i);
      pdata_q <= push_data_i;
    end
  end

  // queue control update
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    tick_d   = tick_q;
    pushed_d = pushed_q;
    popped_d = popped_q;
    sts_d    = STS_OK;
    mem_we   = 1'b0;
    if (ctrl.exec_en) begin
      unique case (act_q)
        ACT_TICK: begin
          tick_d   = tick_q + TICK_W'(1);
          pushed_d = 1'b0;
          popped_d = 1'b0;
        end
        ACT_PUSH: begin
          priority if (pushed_q) begin
            sts_d = STS_DUP_PUSH;
          end else if (cnt_q >= eff_cap) begin
            sts_d = STS_FULL;
          end else begin
            mem_we   = 1'b1;
            tail_d   = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
            cnt_d    = cnt_q + CNT_W'(1);
            pushed_d = 1'b1;
          end
        end
        ACT_POP: begin
          priority if (popped_q) begin
            sts_d = STS_DUP_POP;
          end else if (cnt_q == '0) begin
            sts_d = STS_EMPTY;
          end else begin
            head_d   = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
            cnt_d    = cnt_q - CNT_W'(1);
            popped_d = 1'b1;
          end
        end
        ACT_STATUS: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      tick_q   <= '0;
      pushed_q <= 1'b0;
      popped_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      tick_q   <= tick_d;
      pushed_q <= pushed_d;
      popped_q <= popped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.exec_en) begin
      sts_q <= sts_d;
    end
  end

  assign mem_wdata.data     = pdata_q;
  assign mem_wdata.maturity = tick_q + TICK_W'(latency_q);

  // write lands in S_EXEC, head read in S_READ, so no same-cycle overlap
  dmf_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail_q),
    .wdata_i (mem_wdata),
    .re_i    (ctrl.rd_en),
    .raddr_i (head_q),
    .rdata_o (mem_rdata)
  );

  assign age = tick_q - mem_rdata.maturity;

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl.resp_en) begin
      status_o      <= sts_q;
      head_data_o   <= (cnt_q != '0) ? mem_rdata.data : '0;
      head_ready_o  <= (cnt_q != '0) && !age[TICK_W-1];
      queue_full_o  <= (cnt_q >= eff_cap);
      queue_empty_o <= (cnt_q == '0);
      occupancy_o   <= cnt_q;
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (cnt_q < eff_cap) && !pushed_q)
    else $error("push writes over a live entry");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while a result is pending");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.exec_en && act_q == ACT_POP && sts_d == STS_OK)
      |=> cnt_q == $past(cnt_q) - CNT_W'(1))
    else $error("pop did not lower the count");

endmodule
